/* sv/lsb_stego_payload_extractor_top_defines.svh */
// Assertion helpers for the payload extractor, clocked on clk_i, idle in reset.
`ifndef LSB_STEGO_PAYLOAD_EXTRACTOR_TOP_DEFINES_SVH
`define LSB_STEGO_PAYLOAD_EXTRACTOR_TOP_DEFINES_SVH

// same-cycle implication
`define LSPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lspe_pkg.sv */
package lspe_pkg;

  localparam int unsigned EXT_STORE_BYTES = 20;
  localparam int unsigned MAGIC_MAX_BYTES = 4;

  localparam int unsigned MAGIC_CAP = (MAGIC_MAX_BYTES < 4) ? MAGIC_MAX_BYTES : 4;
  localparam logic [31:0] EXT_LEN_MAX = 32'(EXT_STORE_BYTES - 1);

  localparam logic [7:0]  HEADER_SKIP_RST  = 8'd54;
  localparam logic [2:0]  MAGIC_LENGTH_RST = 3'd2;
  localparam logic [31:0] MAGIC_VALUE_RST  = 32'd0;

  typedef enum logic [1:0] {
    CFG_HEADER_SKIP  = 2'd0,
    CFG_MAGIC_LENGTH = 2'd1,
    CFG_MAGIC_VALUE  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_EXT   = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_MAGIC    = 2'd1,
    ERR_EXT_LONG = 2'd2
  } err_e;

  typedef enum logic [6:0] {
    PH_HEADER = 7'b0000001,
    PH_MAGIC  = 7'b0000010,
    PH_EXTLEN = 7'b0000100,
    PH_EXT    = 7'b0001000,
    PH_SIZE   = 7'b0010000,
    PH_DATA   = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [7:0] value;
    kind_e      kind;
    logic       last;
    err_e       error_code;
  } res_t;

endpackage

/* sv/lsb_stego_payload_extractor_top.sv */
// LSB payload extractor. Takes one cover byte per cycle while in_ready_o is high
// (only bit 0 matters) and registers at most one result word per cover byte into
// the output buffer. Decode state advances with short logic at the input, so in_ready_o
// stays high back to back; a two-entry output buffer lets one result wait on a
// stalled consumer while the next byte is still taken. in_ready_o drops only
// when both entries are full. Config writes are always ready and take effect at once.
`include "lsb_stego_payload_extractor_top_defines.svh"

module lsb_stego_payload_extractor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_of_image_i,
  input  logic [7:0]  cover_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  value_o,
  output logic [1:0]  kind_o,
  output logic        last_o,
  output logic [1:0]  error_code_o
);

  logic [7:0]  header_skip_q;
  logic [2:0]  magic_length_q;
  logic [31:0] magic_value_q;

  lspe_pkg::phase_e phase_q, phase_d;
  logic [4:0]  bit_count_q, bit_count_d;
  logic [31:0] shift_word_q, shift_word_d;
  logic [7:0]  header_count_q, header_count_d;
  logic [31:0] field_count_q, field_count_d;

  lspe_pkg::res_t out_q, skid_q, res;
  logic out_valid_q, skid_valid_q;
  logic push, pop, in_acc;

  logic [2:0]  magic_n;
  logic [31:0] magic_mask;
  logic [5:0]  need;
  logic [31:0] word;
  logic        unit_done;
  logic        hidden;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign pop         = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_skip_q  <= lspe_pkg::HEADER_SKIP_RST;
      magic_length_q <= lspe_pkg::MAGIC_LENGTH_RST;
      magic_value_q  <= lspe_pkg::MAGIC_VALUE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lspe_pkg::CFG_HEADER_SKIP:  header_skip_q  <= cfg_data_i[7:0];
        lspe_pkg::CFG_MAGIC_LENGTH: magic_length_q <= cfg_data_i[2:0];
        lspe_pkg::CFG_MAGIC_VALUE:  magic_value_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp magic length to what the compare supports
  always_comb begin
    if (magic_length_q > 3'(lspe_pkg::MAGIC_CAP)) begin
      magic_n = 3'(lspe_pkg::MAGIC_CAP);
    end else begin
      magic_n = magic_length_q;
    end
    magic_mask = ~(32'hFFFF_FFFF << {magic_n, 3'b000});
  end

  always_comb begin
    phase_d        = phase_q;
    bit_count_d    = bit_count_q;
    shift_word_d   = shift_word_q;
    header_count_d = header_count_q;
    field_count_d  = field_count_q;
    push           = 1'b0;
    res            = '0;
    hidden         = 1'b1;

    if (start_of_image_i) begin
      phase_d        = lspe_pkg::PH_HEADER;
      bit_count_d    = '0;
      shift_word_d   = '0;
      header_count_d = '0;
      field_count_d  = '0;
    end

    if (phase_d == lspe_pkg::PH_HEADER) begin
      if (header_count_d < header_skip_q) begin
        header_count_d = header_count_d + 8'd1;
        hidden         = 1'b0;
      end else begin
        phase_d = lspe_pkg::PH_MAGIC;
      end
    end
    if (phase_d == lspe_pkg::PH_MAGIC && magic_n == 3'd0) begin
      phase_d = lspe_pkg::PH_EXTLEN;
    end

    if (phase_d == lspe_pkg::PH_MAGIC) begin
      need = {magic_n, 3'b000};
    end else if (phase_d == lspe_pkg::PH_EXT || phase_d == lspe_pkg::PH_DATA) begin
      need = 6'd8;
    end else begin
      need = 6'd32;
    end
    word      = {shift_word_d[30:0], cover_byte_i[0]};
    unit_done = ({1'b0, bit_count_d} + 6'd1) >= need;

    if (hidden && phase_d != lspe_pkg::PH_DONE) begin
      if (!unit_done) begin
        bit_count_d  = bit_count_d + 5'd1;
        shift_word_d = word;
      end else begin
        bit_count_d  = '0;
        shift_word_d = '0;
        case (phase_d)
          lspe_pkg::PH_MAGIC: begin
            if (((word ^ magic_value_q) & magic_mask) != 32'd0) begin
              phase_d        = lspe_pkg::PH_DONE;
              push           = 1'b1;
              res.kind       = lspe_pkg::KIND_ERROR;
              res.last       = 1'b1;
              res.error_code = lspe_pkg::ERR_MAGIC;
            end else begin
              phase_d = lspe_pkg::PH_EXTLEN;
            end
          end
          lspe_pkg::PH_EXTLEN: begin
            if (word > lspe_pkg::EXT_LEN_MAX) begin
              phase_d        = lspe_pkg::PH_DONE;
              push           = 1'b1;
              res.kind       = lspe_pkg::KIND_ERROR;
              res.last       = 1'b1;
              res.error_code = lspe_pkg::ERR_EXT_LONG;
            end else begin
              field_count_d = word;
              phase_d = (word != 32'd0) ? lspe_pkg::PH_EXT : lspe_pkg::PH_SIZE;
            end
          end
          lspe_pkg::PH_EXT: begin
            field_count_d = field_count_d - 32'd1;
            if (field_count_d == 32'd0) begin
              phase_d = lspe_pkg::PH_SIZE;
            end
            push      = 1'b1;
            res.value = word[7:0];
            res.kind  = lspe_pkg::KIND_EXT;
          end
          lspe_pkg::PH_SIZE: begin
            if (word == 32'd0 || word[31]) begin
              phase_d  = lspe_pkg::PH_DONE;
              push     = 1'b1;
              res.kind = lspe_pkg::KIND_EMPTY;
              res.last = 1'b1;
            end else begin
              field_count_d = word;
              phase_d       = lspe_pkg::PH_DATA;
            end
          end
          lspe_pkg::PH_DATA: begin
            field_count_d = field_count_d - 32'd1;
            push      = 1'b1;
            res.value = word[7:0];
            res.kind  = lspe_pkg::KIND_DATA;
            if (field_count_d == 32'd0) begin
              phase_d  = lspe_pkg::PH_DONE;
              res.last = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= lspe_pkg::PH_HEADER;
      bit_count_q    <= '0;
      shift_word_q   <= '0;
      header_count_q <= '0;
      field_count_q  <= '0;
    end else if (in_acc) begin
      phase_q        <= phase_d;
      bit_count_q    <= bit_count_d;
      shift_word_q   <= shift_word_d;
      header_count_q <= header_count_d;
      field_count_q  <= field_count_d;
    end
  end

  // two-entry output buffer: out_q is the head, skid_q holds a second word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc && push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (in_acc && push) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = out_q.value;
  assign kind_o       = out_q.kind;
  assign last_o       = out_q.last;
  assign error_code_o = out_q.error_code;

  `LSPE_ASSERT_NOW(a_skid_needs_head, skid_valid_q, out_valid_q, "skid word without head word")
  `LSPE_ASSERT_NEXT(a_skid_holds, skid_valid_q && !out_ready_i, skid_valid_q, "skid word lost")
  `LSPE_ASSERT_NEXT(a_last_ends, in_acc && push && res.last, phase_q == lspe_pkg::PH_DONE, "decode not done after last word")

endmodule
